// ----- design/sito_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sito_pkg
// Shared constants, types and the division step for the strided offset unit.
// ----------------------------------------------------------------------------
package sito_pkg;

  localparam int unsigned NDIM           = 4;
  localparam int unsigned IDX_W          = 32;
  localparam int unsigned SIZE_W         = 16;
  localparam int unsigned DVS_W          = SIZE_W + 1;
  localparam int unsigned STRIDE_W       = 32;
  localparam int unsigned OFS_W          = 48;
  localparam int unsigned APB_DW         = 32;
  localparam int unsigned APB_AW         = 5;
  localparam int unsigned BITS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES     = IDX_W / BITS_PER_STAGE;
  localparam int unsigned DEF_RANK       = 4;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_SIZE_0   = 3'd0,
    REG_SIZE_1   = 3'd1,
    REG_SIZE_2   = 3'd2,
    REG_SIZE_3   = 3'd3,
    REG_STRIDE_0 = 3'd4,
    REG_STRIDE_1 = 3'd5,
    REG_STRIDE_2 = 3'd6,
    REG_STRIDE_3 = 3'd7
  } reg_idx_e;

  // Working state of the restoring divider: the dividend shifts out at the
  // top while quotient bits shift in at the bottom.
  typedef struct packed {
    logic [IDX_W-1:0] num;
    logic [DVS_W-1:0] rem;
  } div_state_t;

  function automatic div_state_t div_bits(div_state_t s, logic [DVS_W-1:0] dvs);
    div_state_t r;
    logic [DVS_W:0] t;
    r = s;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      t = {r.rem, r.num[IDX_W-1]};
      r.num = {r.num[IDX_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
        r.num[0] = 1'b1;
      end
      r.rem = t[DVS_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/strided_index_to_offset.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// strided_index_to_offset
// Turns a flat element index into a strided memory offset over four dims.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     start_i / busy_o      linear_index_i
//  result    done_o (strobe)       element_offset_o
//  config    APB psel/penable/...  pwdata, prdata
//
// One item enters every cycle; busy_o stays low. Each result passes, per
// dimension, through the pipelined divider (DIV_STAGES stages of four
// quotient bits) and one multiply stage, then through an output register.
// Reset clears the valid bits and restores the registers.
// The receiver cannot stall, so the pipeline never holds.
module strided_index_to_offset #(
  parameter int unsigned RANK = sito_pkg::DEF_RANK
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [sito_pkg::IDX_W-1:0]    linear_index_i,
  output logic                               done_o,
  output logic [sito_pkg::OFS_W-1:0]         element_offset_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sito_pkg::APB_AW-1:0]   paddr,
  input  wire logic [sito_pkg::APB_DW-1:0]   pwdata,
  output logic [sito_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);
  import sito_pkg::*;

  localparam int unsigned STEP_STAGES = DIV_STAGES + 1;
  localparam int unsigned NST         = RANK * STEP_STAGES;
  localparam int unsigned LAT         = NST + 1;

  logic [SIZE_W-1:0]   size_q   [NDIM];
  logic [STRIDE_W-1:0] stride_q [NDIM];
  reg_idx_e            reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign busy_o  = 1'b0;
  assign reg_idx = reg_idx_e'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NDIM; i++) begin
        size_q[i]   <= SIZE_W'(1);
        stride_q[i] <= '0;
      end
      stride_q[NDIM-1] <= STRIDE_W'(1);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SIZE_0:   size_q[0]   <= pwdata[SIZE_W-1:0];
        REG_SIZE_1:   size_q[1]   <= pwdata[SIZE_W-1:0];
        REG_SIZE_2:   size_q[2]   <= pwdata[SIZE_W-1:0];
        REG_SIZE_3:   size_q[3]   <= pwdata[SIZE_W-1:0];
        REG_STRIDE_0: stride_q[0] <= pwdata[STRIDE_W-1:0];
        REG_STRIDE_1: stride_q[1] <= pwdata[STRIDE_W-1:0];
        REG_STRIDE_2: stride_q[2] <= pwdata[STRIDE_W-1:0];
        REG_STRIDE_3: stride_q[3] <= pwdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SIZE_0:   prdata = APB_DW'(size_q[0]);
      REG_SIZE_1:   prdata = APB_DW'(size_q[1]);
      REG_SIZE_2:   prdata = APB_DW'(size_q[2]);
      REG_SIZE_3:   prdata = APB_DW'(size_q[3]);
      REG_STRIDE_0: prdata = stride_q[0];
      REG_STRIDE_1: prdata = stride_q[1];
      REG_STRIDE_2: prdata = stride_q[2];
      REG_STRIDE_3: prdata = stride_q[3];
      default:      prdata = '0;
    endcase
  end

  // Pipeline: per dimension, DIV_STAGES divider stages then a multiply stage.
  // The product is folded into the offset at the next dimension's first stage.
  logic             vld_q  [NST];
  logic [IDX_W-1:0] num_q  [NST];
  logic [DVS_W-1:0] rem_q  [NST];
  logic [OFS_W-1:0] ofs_q  [NST];
  logic [OFS_W-1:0] prod_q [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    localparam int unsigned K = s / STEP_STAGES;
    localparam int unsigned J = s % STEP_STAGES;
    localparam int unsigned D = NDIM - 1 - K;

    logic             vld_in;
    logic [IDX_W-1:0] num_in;
    logic [DVS_W-1:0] rem_in;
    logic [OFS_W-1:0] ofs_in;
    logic [OFS_W-1:0] prod_in;
    logic [DVS_W-1:0] dvs;
    div_state_t       dst;
    logic [IDX_W-1:0] num_d;
    logic [DVS_W-1:0] rem_d;
    logic [OFS_W-1:0] ofs_d;
    logic [OFS_W-1:0] prod_d;

    if (s == 0) begin : g_first
      assign vld_in  = start_i;
      assign num_in  = linear_index_i;
      assign rem_in  = '0;
      assign ofs_in  = '0;
      assign prod_in = '0;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign num_in  = num_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign ofs_in  = ofs_q[s-1];
      assign prod_in = prod_q[s-1];
    end

    // A size of zero divides by 65536.
    assign dvs = (size_q[D] == '0) ? {1'b1, SIZE_W'(0)} : {1'b0, size_q[D]};

    always_comb begin
      dst    = '0;
      num_d  = num_in;
      rem_d  = rem_in;
      ofs_d  = ofs_in;
      prod_d = prod_in;
      if (J == 0) begin
        dst    = div_bits({num_in, DVS_W'(0)}, dvs);
        num_d  = dst.num;
        rem_d  = dst.rem;
        ofs_d  = ofs_in + prod_in;
        prod_d = '0;
      end else if (J < DIV_STAGES) begin
        dst   = div_bits({num_in, rem_in}, dvs);
        num_d = dst.num;
        rem_d = dst.rem;
      end else begin
        prod_d = rem_in[SIZE_W-1:0] * stride_q[D];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[s]  <= num_d;
      rem_q[s]  <= rem_d;
      ofs_q[s]  <= ofs_d;
      prod_q[s] <= prod_d;
    end
  end

  logic             done_q;
  logic [OFS_W-1:0] result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= ofs_q[NST-1] + prod_q[NST-1];
  end

  assign done_o           = done_q;
  assign element_offset_o = result_q;

  // Every result traces back to an item accepted on start_i, carried through every stage and the output register.
  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result without a matching item");

  // An accepted item enters the first stage.
  a_item_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> vld_q[0])
    else $error("accepted item lost at pipeline entry");

endmodule
`default_nettype wire
